@@ design/wsdfr_pkg.sv @@
// Shared types and constants for the WebSocket frame deframer.
// Holds the result record carried between the parser, the queue and the output stage.
// No dependencies.
package wsdfr_pkg;

    localparam int LEN_W   = 24;
    localparam int LIM_W   = 25;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(1) << LEN_W;

    localparam logic [1:0] KIND_HEADER  = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_END     = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    localparam logic [1:0] ERR_UNMASKED  = 2'd0;
    localparam logic [1:0] ERR_TOO_LARGE = 2'd1;
    localparam logic [1:0] ERR_HEADER    = 2'd2;
    localparam logic [1:0] ERR_PAYLOAD   = 2'd3;

    typedef struct packed {
        logic [1:0]       kind;
        logic [3:0]       opcode;
        logic             fin;
        logic [LEN_W-1:0] length;
        logic [7:0]       data;
        logic [7:0]       key;
        logic             last;
        logic [1:0]       error_code;
    } t_rec;

endpackage

@@ design/wsdfr_front.sv @@
// Front part of the deframer: accepts stream words, parses frame headers and
// turns header, payload, end and error events into result records for the queue.
// Depends on wsdfr_pkg.
module wsdfr_front (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic                     i_action,
    input  logic [7:0]               i_data_byte,
    input  logic                     i_cfg_we,
    input  logic [wsdfr_pkg::LIM_W-1:0] i_cfg_data,
    input  logic                     i_q_full,
    output logic                     o_push,
    output wsdfr_pkg::t_rec          o_rec
);
    import wsdfr_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_SECOND  = 3'd1;
    localparam logic [2:0] PH_EXTLEN  = 3'd2;
    localparam logic [2:0] PH_KEY     = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    logic [2:0]       r_phase, n_phase;
    logic             r_fin, n_fin;
    logic [3:0]       r_op, n_op;
    logic             r_masked, n_masked;
    logic [LEN_W-1:0] r_len, n_len;
    logic             r_high, n_high;
    logic [2:0]       r_cnt, n_cnt;
    logic [31:0]      r_key, n_key;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [LIM_W-1:0] r_limit;

    logic       accept;
    logic       len_known;
    logic       hdr_emit;
    logic [7:0] key_byte;
    logic       pay_last;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        case (r_pos[1:0])
            2'd0:    key_byte = r_key[31:24];
            2'd1:    key_byte = r_key[23:16];
            2'd2:    key_byte = r_key[15:8];
            default: key_byte = r_key[7:0];
        endcase
        pay_last = ({1'b0, r_pos} + (LEN_W+1)'(1)) >= {1'b0, r_len};
    end

    always_comb begin
        n_phase   = r_phase;
        n_fin     = r_fin;
        n_op      = r_op;
        n_masked  = r_masked;
        n_len     = r_len;
        n_high    = r_high;
        n_cnt     = r_cnt;
        n_key     = r_key;
        n_pos     = r_pos;
        o_push    = 1'b0;
        o_rec     = '0;
        len_known = 1'b0;
        hdr_emit  = 1'b0;

        if (accept) begin
            if (i_action) begin
                case (r_phase)
                    PH_IDLE: begin
                        o_push    = 1'b1;
                        o_rec.kind = KIND_END;
                    end
                    PH_SECOND, PH_EXTLEN, PH_KEY: begin
                        o_push           = 1'b1;
                        o_rec.kind       = KIND_ERROR;
                        o_rec.last       = 1'b1;
                        o_rec.error_code = ERR_HEADER;
                        n_phase          = PH_IDLE;
                    end
                    PH_PAYLOAD: begin
                        o_push           = 1'b1;
                        o_rec.kind       = KIND_ERROR;
                        o_rec.last       = 1'b1;
                        o_rec.error_code = ERR_PAYLOAD;
                        n_phase          = PH_IDLE;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end else begin
                case (r_phase)
                    PH_IDLE: begin
                        n_fin    = i_data_byte[7];
                        n_op     = i_data_byte[3:0];
                        n_masked = 1'b0;
                        n_len    = '0;
                        n_high   = 1'b0;
                        n_key    = '0;
                        n_pos    = '0;
                        n_phase  = PH_SECOND;
                    end
                    PH_SECOND: begin
                        n_masked = i_data_byte[7];
                        if (!i_data_byte[7] && (i_data_byte[6:0] != 7'd0)) begin
                            o_push           = 1'b1;
                            o_rec.kind       = KIND_ERROR;
                            o_rec.last       = 1'b1;
                            o_rec.error_code = ERR_UNMASKED;
                            n_phase          = PH_DISCARD;
                        end else if (i_data_byte[6:0] == 7'd126) begin
                            n_len   = '0;
                            n_high  = 1'b0;
                            n_cnt   = 3'd1;
                            n_phase = PH_EXTLEN;
                        end else if (i_data_byte[6:0] == 7'd127) begin
                            n_len   = '0;
                            n_high  = 1'b0;
                            n_cnt   = 3'd7;
                            n_phase = PH_EXTLEN;
                        end else begin
                            n_len     = LEN_W'(i_data_byte[6:0]);
                            n_high    = 1'b0;
                            len_known = 1'b1;
                        end
                    end
                    PH_EXTLEN: begin
                        n_len  = {r_len[LEN_W-9:0], i_data_byte};
                        n_high = r_high || (r_len[LEN_W-1:LEN_W-8] != 8'd0);
                        if (r_cnt == 3'd0) begin
                            len_known = 1'b1;
                        end else begin
                            n_cnt = r_cnt - 3'd1;
                        end
                    end
                    PH_KEY: begin
                        n_key = {r_key[23:0], i_data_byte};
                        if (r_cnt == 3'd0) begin
                            hdr_emit = 1'b1;
                        end else begin
                            n_cnt = r_cnt - 3'd1;
                        end
                    end
                    PH_PAYLOAD: begin
                        o_push       = 1'b1;
                        o_rec.kind   = KIND_PAYLOAD;
                        o_rec.opcode = r_op;
                        o_rec.fin    = r_fin;
                        o_rec.length = r_len;
                        o_rec.data   = i_data_byte;
                        o_rec.key    = key_byte;
                        o_rec.last   = pay_last;
                        n_pos        = r_pos + LEN_W'(1);
                        if (pay_last) begin
                            n_phase = PH_IDLE;
                        end
                    end
                    default: begin
                    end
                endcase

                // Once the length is complete it is checked, then the key follows
                // or, for an unmasked empty frame, the header goes out at once.
                if (len_known) begin
                    if (n_high || ({1'b0, n_len} >= r_limit)) begin
                        o_push           = 1'b1;
                        o_rec.kind       = KIND_ERROR;
                        o_rec.last       = 1'b1;
                        o_rec.error_code = ERR_TOO_LARGE;
                        n_phase          = PH_DISCARD;
                    end else if (n_masked) begin
                        n_cnt   = 3'd3;
                        n_key   = '0;
                        n_phase = PH_KEY;
                    end else begin
                        hdr_emit = 1'b1;
                    end
                end

                if (hdr_emit) begin
                    o_push       = 1'b1;
                    o_rec.kind   = KIND_HEADER;
                    o_rec.opcode = r_op;
                    o_rec.fin    = r_fin;
                    o_rec.length = n_len;
                    o_rec.last   = (n_len == '0);
                    n_pos        = '0;
                    n_phase      = (n_len == '0) ? PH_IDLE : PH_PAYLOAD;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_fin    <= 1'b0;
            r_op     <= '0;
            r_masked <= 1'b0;
            r_len    <= '0;
            r_high   <= 1'b0;
            r_cnt    <= '0;
            r_key    <= '0;
            r_pos    <= '0;
            r_limit  <= LIMIT_RESET;
        end else begin
            r_phase  <= n_phase;
            r_fin    <= n_fin;
            r_op     <= n_op;
            r_masked <= n_masked;
            r_len    <= n_len;
            r_high   <= n_high;
            r_cnt    <= n_cnt;
            r_key    <= n_key;
            r_pos    <= n_pos;
            if (i_cfg_we) begin
                r_limit <= i_cfg_data;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_payload_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAYLOAD) |-> ((r_len != '0) && !r_high && (r_pos < r_len)))
        else $error("payload phase with inconsistent length or position");

    a_key_needs_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_KEY) |-> r_masked)
        else $error("key phase entered for an unmasked frame");

    a_no_push_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> (i_in_valid && !i_q_full))
        else $error("record pushed without an accepted word");
`endif

endmodule

@@ design/wsdfr_queue.sv @@
// Short record queue between the parser and the output stage.
// Depends on wsdfr_pkg.
module wsdfr_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  wsdfr_pkg::t_rec i_rec,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output wsdfr_pkg::t_rec o_rec
);
    import wsdfr_pkg::*;

    t_rec               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr, n_wr;
    logic [Q_PTR_W-1:0] r_rd, n_rd;
    logic [Q_CNT_W-1:0] r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr    = do_push ? r_wr + Q_PTR_W'(1) : r_wr;
        n_rd    = do_pop ? r_rd + Q_PTR_W'(1) : r_rd;
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + Q_CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CNT_W'(Q_DEPTH))
        else $error("queue count beyond depth");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> (r_count == $past(r_count) + Q_CNT_W'(1)))
        else $error("queue count did not follow a push");

    a_no_lost_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("record pushed into a full queue");
`endif

endmodule

@@ design/wsdfr_back.sv @@
// Back part of the deframer: takes records from the queue, unmasks payload
// bytes and holds the result word in the output register. Depends on wsdfr_pkg.
module wsdfr_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_q_valid,
    input  wsdfr_pkg::t_rec           i_q_rec,
    output logic                      o_q_pop,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_kind,
    output logic [3:0]                o_opcode,
    output logic                      o_fin,
    output logic [wsdfr_pkg::LEN_W-1:0] o_payload_length,
    output logic [7:0]                o_payload_byte,
    output logic                      o_last,
    output logic [1:0]                o_error_code
);
    import wsdfr_pkg::*;

    logic r_valid, n_valid;
    t_rec r_rec, n_rec;

    assign o_q_pop = i_q_valid && (!r_valid || !i_out_stall);
    assign n_valid = o_q_pop || (r_valid && i_out_stall);

    always_comb begin
        n_rec      = i_q_rec;
        n_rec.data = i_q_rec.data ^ i_q_rec.key;
        n_rec.key  = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= n_rec;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_kind           = r_rec.kind;
    assign o_opcode         = r_rec.opcode;
    assign o_fin            = r_rec.fin;
    assign o_payload_length = r_rec.length;
    assign o_payload_byte   = r_rec.data;
    assign o_last           = r_rec.last;
    assign o_error_code     = r_rec.error_code;

endmodule

@@ design/websocket_frame_deframer.sv @@
// Top level of the WebSocket frame deframer: parser, record queue and output stage.
// Depends on wsdfr_pkg, wsdfr_front, wsdfr_queue and wsdfr_back.
//
//   channel   direction  handshake                  payload
//   input     in         i_in_valid / o_in_stall    i_action, i_data_byte
//   result    out        o_out_valid / i_out_stall  o_kind .. o_error_code
//   config    in         i_cfg_we                   i_cfg_data (payload limit)
//
// One stream word is taken per cycle while the input is not stalled; each gives at most one result word.
// A result word is first written into the record queue and then loaded into the output register
// once that register is empty or not held by i_out_stall.
// The input stalls only while the four-entry record queue is full.
// Reset is synchronous and active low and needs no clearing pass.
module websocket_frame_deframer (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic                      i_action,
    input  logic [7:0]                i_data_byte,
    input  logic                      i_cfg_we,
    input  logic [wsdfr_pkg::LIM_W-1:0] i_cfg_data,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_kind,
    output logic [3:0]                o_opcode,
    output logic                      o_fin,
    output logic [wsdfr_pkg::LEN_W-1:0] o_payload_length,
    output logic [7:0]                o_payload_byte,
    output logic                      o_last,
    output logic [1:0]                o_error_code
);
    import wsdfr_pkg::*;

    logic q_full;
    logic q_push;
    logic q_valid;
    logic q_pop;
    t_rec push_rec;
    t_rec head_rec;

    wsdfr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_rec       (push_rec)
    );

    wsdfr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (push_rec),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_rec   (head_rec)
    );

    wsdfr_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_valid        (q_valid),
        .i_q_rec          (head_rec),
        .o_q_pop          (q_pop),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_opcode         (o_opcode),
        .o_fin            (o_fin),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last),
        .o_error_code     (o_error_code)
    );

endmodule
